[design/drift_table_interpolator_defines.svh]
// ----------------------------------------------------------------------------
// Drift table interpolator assertion macros
// Property wrappers shared by the block's RTL; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef DRIFT_TABLE_INTERPOLATOR_DEFINES_SVH
`define DRIFT_TABLE_INTERPOLATOR_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define DTI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define DTI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DTI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define DTI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[design/dti_pkg.sv]
// ----------------------------------------------------------------------------
// Drift table interpolator package
// Field widths, opcodes, register indexes and controller types.
// ----------------------------------------------------------------------------
package dti_pkg;

    localparam int DTI_TABLE_DEPTH = 64;

    localparam int OP_W       = 3;
    localparam int IDX_W      = 6;
    localparam int COUNT_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 272;
    localparam int M_TDATA_W  = 168;

    localparam logic [OP_W-1:0] OP_LOAD_VEL   = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD_LONG  = 3'd1;
    localparam logic [OP_W-1:0] OP_LOAD_TRANS = 3'd2;
    localparam logic [OP_W-1:0] OP_VEL_QUERY  = 3'd3;
    localparam logic [OP_W-1:0] OP_DIFF_QUERY = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_VEL_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CONST_VEL   = 2'd3;

    localparam logic [31:0] CONST_VEL_RESET = 32'd429497;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOADV,
        ST_SQ,
        ST_SQ_END,
        ST_SQRT,
        ST_SQ_RET,
        ST_LK_A0,
        ST_LK_AN,
        ST_LK_CHK,
        ST_LK_SCAN,
        ST_LK_MUL,
        ST_LK_DSET,
        ST_LK_DIV,
        ST_LK_FIN,
        ST_LK_RET,
        ST_CV_DIV,
        ST_CV_WR,
        ST_VC_MUL,
        ST_VC_CHK,
        ST_VC_DIV,
        ST_VC_NEXT,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        TB_VEL,
        TB_LONG,
        TB_TRANS
    } tbl_t;

    // who started a table lookup, decides where its result goes
    typedef enum logic [1:0] {
        LC_VLOAD,
        LC_VQUERY,
        LC_LONG,
        LC_TRANS
    } lk_ctx_t;

endpackage

[design/drift_table_interpolator.sv]
// ----------------------------------------------------------------------------
// Drift table interpolator
// Piecewise-linear drift velocity and diffusion tables with on-load
// conversion of raw diffusion to sqrt(2D/|v|).
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tuser op, s_tdata fields (see port)
//  m_*     | out | m_tvalid/m_tready  | m_tuser status, m_tdata results
//  cfg_*   | in  | cfg_wen            | cfg_addr register, cfg_wdata value
//
//  One item at a time; every item yields one transfer on m_*.
//  Velocity load: a RAM write. Field magnitude: squares on the shared
//  multiplier, one root bit per cycle. Lookup: constant velocity on an empty
//  velocity table, else a linear scan of the table RAM, plus an interpolation
//  (multiply, 32-step divide). Velocity query: magnitude, lookup, per component
//  multiply, divide (none if saturated); diffusion load: lookup, divide, root.
//  All three tables share one RAM, addressed {table, row}, row = {value, key}.
//  No clearing pass after reset: table rows are undefined until loaded.
//  A result waiting on m_tready holds the output register; the next item is
//  still taken and stalls only when its own result is ready.
// ----------------------------------------------------------------------------
`include "drift_table_interpolator_defines.svh"

module drift_table_interpolator
    import dti_pkg::*;
#(
    parameter int TABLE_DEPTH = DTI_TABLE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // ex[31:0] ey[63:32] ez[95:64] bx[127:96] by[159:128] bz[191:160]
    // entry_index[197:192] entry_key[229:198] entry_value[269:230]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // op[2:0]
    input  logic [OP_W-1:0]       s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // vel_x[32:0] vel_y[65:33] vel_z[98:66] diff_long[130:99]
    // diff_trans[162:131]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // status[0]
    output logic                  m_tuser,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NW = AW + 1;                         // holds TABLE_DEPTH
    localparam int CW = (NW > COUNT_W) ? NW : COUNT_W;
    localparam int XW = (NW > IDX_W) ? NW : IDX_W;
    localparam int RAM_DEPTH = 3 * (1 << AW);           // {table, row}

    // ---------------- configuration registers ----------------
    logic [COUNT_W-1:0] vel_count_reg, long_count_reg, trans_count_reg;
    logic [31:0]        const_vel_reg;

    function automatic logic [CW-1:0] eff_count(input logic [COUNT_W-1:0] c);
        logic [CW-1:0] cw;
        cw = CW'(c);
        return (cw > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : cw;
    endfunction

    logic [CW-1:0] nv, nl, nt;
    assign nv = eff_count(vel_count_reg);
    assign nl = eff_count(long_count_reg);
    assign nt = eff_count(trans_count_reg);

    // ---------------- input fields ----------------
    logic [31:0] in_ex, in_ey, in_ez, in_key;
    logic [5:0]  in_idx;
    logic [39:0] in_val;
    logic        in_b_nz, in_idx_ok, in_is_query;
    logic [XW-1:0] in_idx_w;

    assign in_ex     = s_tdata[31:0];
    assign in_ey     = s_tdata[63:32];
    assign in_ez     = s_tdata[95:64];
    assign in_b_nz   = |s_tdata[191:96];
    assign in_idx    = s_tdata[197:192];
    assign in_key    = s_tdata[229:198];
    assign in_val    = s_tdata[269:230];
    assign in_idx_w  = XW'(in_idx);
    assign in_idx_ok = in_idx_w < XW'(TABLE_DEPTH);
    assign in_is_query = (s_tuser == OP_VEL_QUERY) || (s_tuser == OP_DIFF_QUERY);

    // ---------------- state ----------------
    state_t state_reg, state_next;
    logic       m_tvalid_reg;
    logic [1:0] cnt_reg;        // field component
    logic [6:0] itr_reg;        // divide / root step counter
    logic       out_free;

    // item registers
    logic [OP_W-1:0] op_reg;
    logic [31:0]     mag_x_reg, mag_y_reg, mag_z_reg;
    logic [2:0]      neg_reg;
    logic [31:0]     key_reg;
    logic [39:0]     raw_reg;
    logic [XW-1:0]   idx_reg;
    logic [31:0]     e_reg;

    // result registers
    logic        res_status_reg;
    logic [32:0] res_vx_reg, res_vy_reg, res_vz_reg;
    logic [31:0] res_dl_reg, res_dt_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic        m_user_reg;

    // lookup sequencer
    lk_ctx_t     lk_ctx_reg;
    tbl_t        lk_tab_reg;
    logic [NW-1:0] lk_n_reg, lk_i_reg;
    logic [31:0] lk_e_reg, lk_k0_reg, lk_y0_reg, lk_k1_reg, lk_y1_reg;
    logic [31:0] lk_yn_reg, lk_res_reg;
    logic        lk_up_reg;
    logic [31:0] vel_v_reg, cm_reg;

    // arithmetic units
    logic [63:0] prod_reg, acc_reg;
    logic [31:0] div_rem_reg, div_d_reg;
    logic [63:0] div_q_reg;
    logic [63:0] sx_reg;
    logic [32:0] srem_reg;
    logic [31:0] sroot_reg;

    // ---------------- table RAM: row = {value, key} ----------------
    logic [AW-1:0] ram_addr;
    tbl_t          ram_tab;
    logic [AW+1:0] ram_full_addr;
    logic          ram_we;
    logic [63:0]   ram_wdata;
    logic          we_vel, we_long, we_trans;
    logic [63:0]   rd_row;
    logic [31:0]   rd_key, rd_val;

    assign ram_we        = we_vel || we_long || we_trans;
    assign ram_full_addr = {ram_tab, ram_addr};

    dti_ram #(.WIDTH(64), .DEPTH(RAM_DEPTH)) u_table_ram (
        .clk(clk), .we(ram_we), .addr(ram_full_addr), .wdata(ram_wdata), .rdata(rd_row)
    );

    assign rd_key = rd_row[31:0];
    assign rd_val = rd_row[63:32];

    // ---------------- shared datapath pieces ----------------
    logic [NW-1:0] lk_nm1, lk_ip1;
    assign lk_nm1 = lk_n_reg - NW'(1);
    assign lk_ip1 = lk_i_reg + NW'(1);

    logic [31:0] mag_sel;
    always_comb
    begin
        unique case (cnt_reg)
            2'd0:    mag_sel = mag_x_reg;
            2'd1:    mag_sel = mag_y_reg;
            default: mag_sel = mag_z_reg;
        endcase
    end

    // single 32x32 multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    always_comb
    begin
        priority if (state_reg == ST_LK_MUL)
        begin
            mul_a = (lk_y1_reg >= lk_y0_reg) ? lk_y1_reg - lk_y0_reg
                                             : lk_y0_reg - lk_y1_reg;
            mul_b = lk_e_reg - lk_k0_reg;
        end
        else if (state_reg == ST_VC_MUL)
        begin
            mul_a = mag_sel;
            mul_b = vel_v_reg;
        end
        else
        begin
            mul_a = mag_sel;
            mul_b = mag_sel;
        end
    end
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // restoring divider step, remainder always below divisor
    logic [32:0] div_sh, div_sub;
    logic        div_ge;
    logic [31:0] div_rem_n;
    logic [63:0] div_q_n;
    assign div_sh    = {div_rem_reg, div_q_reg[63]};
    assign div_ge    = div_sh >= {1'b0, div_d_reg};
    assign div_sub   = div_sh - {1'b0, div_d_reg};
    assign div_rem_n = div_ge ? div_sub[31:0] : div_sh[31:0];
    assign div_q_n   = {div_q_reg[62:0], div_ge};

    // square root, one root bit per step
    logic [34:0] sq_sh, sq_trial, sq_sub;
    logic        sq_ge;
    logic [32:0] srem_n;
    logic [31:0] sroot_n;
    assign sq_sh    = {srem_reg, sx_reg[63:62]};
    assign sq_trial = {1'b0, sroot_reg, 2'b01};
    assign sq_ge    = sq_sh >= sq_trial;
    assign sq_sub   = sq_sh - sq_trial;
    assign srem_n   = sq_ge ? sq_sub[32:0] : sq_sh[32:0];
    assign sroot_n  = {sroot_reg[30:0], sq_ge};

    // raw diffusion that gives a quotient of 2^64 or more saturates
    logic cv_sat;
    assign cv_sat = (lk_res_reg == 32'd0) || ({15'd0, raw_reg[39:23]} >= lk_res_reg);

    logic [32:0] vc_val;
    assign vc_val = (!neg_reg[cnt_reg] && (cm_reg != 32'd0)) ? 33'd0 - {1'b0, cm_reg}
                                                             : {1'b0, cm_reg};

    logic op_is_load;
    assign op_is_load = (op_reg == OP_LOAD_LONG) || (op_reg == OP_LOAD_TRANS);

    assign out_free = !m_tvalid_reg || m_tready;

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    priority if (s_tuser == OP_LOAD_VEL)
                        state_next = in_idx_ok ? ST_LOADV : ST_OUT;
                    else if ((s_tuser == OP_LOAD_LONG) || (s_tuser == OP_LOAD_TRANS))
                        state_next = in_idx_ok ? ST_LK_A0 : ST_OUT;
                    else if (in_is_query)
                        state_next = in_b_nz ? ST_OUT : ST_SQ;
                    else
                        state_next = ST_OUT;
                end
            end
            ST_LOADV:   state_next = ST_OUT;
            ST_SQ:      if (cnt_reg == 2'd2) state_next = ST_SQ_END;
            ST_SQ_END:  state_next = ST_SQRT;
            ST_SQRT:    if (itr_reg == 7'd1) state_next = ST_SQ_RET;
            ST_SQ_RET:
            begin
                priority if (op_is_load)
                    state_next = ST_CV_WR;
                else if (op_reg == OP_VEL_QUERY)
                    state_next = (sroot_reg == 32'd0) ? ST_OUT : ST_LK_A0;
                else
                    state_next = ((nl == '0) && (nt == '0)) ? ST_OUT : ST_LK_A0;
            end
            ST_LK_A0:   state_next = (lk_n_reg == '0) ? ST_LK_RET : ST_LK_AN;
            ST_LK_AN:   state_next = ST_LK_CHK;
            ST_LK_CHK:
            begin
                if ((lk_e_reg < lk_k0_reg) || (lk_e_reg > rd_key) || (lk_n_reg == NW'(1)))
                    state_next = ST_LK_RET;
                else
                    state_next = ST_LK_SCAN;
            end
            ST_LK_SCAN:
            begin
                priority if (rd_key > lk_e_reg)
                    state_next = (rd_key <= lk_k0_reg) ? ST_LK_RET : ST_LK_MUL;
                else if (lk_ip1 == lk_n_reg)
                    state_next = ST_LK_RET;
                else
                    state_next = ST_LK_SCAN;
            end
            ST_LK_MUL:  state_next = ST_LK_DSET;
            ST_LK_DSET: state_next = ST_LK_DIV;
            ST_LK_DIV:  if (itr_reg == 7'd1) state_next = ST_LK_FIN;
            ST_LK_FIN:  state_next = ST_LK_RET;
            ST_LK_RET:
            begin
                unique case (lk_ctx_reg)
                    LC_VLOAD:  state_next = cv_sat ? ST_CV_WR : ST_CV_DIV;
                    LC_VQUERY: state_next = ST_VC_MUL;
                    LC_LONG:   state_next = (nt != '0) ? ST_LK_A0 : ST_OUT;
                    LC_TRANS:  state_next = ST_OUT;
                endcase
            end
            ST_CV_DIV:  if (itr_reg == 7'd1) state_next = ST_SQRT;
            ST_CV_WR:   state_next = ST_OUT;
            ST_VC_MUL:  state_next = ST_VC_CHK;
            ST_VC_CHK:  state_next = (prod_reg[63:32] >= e_reg) ? ST_VC_NEXT : ST_VC_DIV;
            ST_VC_DIV:  if (itr_reg == 7'd1) state_next = ST_VC_NEXT;
            ST_VC_NEXT: state_next = (cnt_reg == 2'd2) ? ST_OUT : ST_VC_MUL;
            ST_OUT:     if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb
    begin
        s_tready  = 1'b0;
        we_vel    = 1'b0;
        we_long   = 1'b0;
        we_trans  = 1'b0;
        ram_addr  = '0;
        ram_tab   = lk_tab_reg;
        ram_wdata = {lk_res_reg, key_reg};
        unique case (state_reg)
            ST_IDLE:    s_tready = 1'b1;
            ST_LOADV:
            begin
                ram_addr  = idx_reg[AW-1:0];
                ram_tab   = TB_VEL;
                ram_wdata = {((raw_reg[39:32] != 8'd0) ? 32'hFFFF_FFFF : raw_reg[31:0]),
                             key_reg};
                we_vel    = 1'b1;
            end
            ST_CV_WR:
            begin
                ram_addr = idx_reg[AW-1:0];
                ram_tab  = (op_reg == OP_LOAD_LONG) ? TB_LONG : TB_TRANS;
                we_long  = (op_reg == OP_LOAD_LONG);
                we_trans = (op_reg == OP_LOAD_TRANS);
            end
            ST_LK_AN:   ram_addr = lk_nm1[AW-1:0];
            ST_LK_CHK:  ram_addr = AW'(1);
            ST_LK_SCAN: ram_addr = lk_ip1[AW-1:0];
            default:    ram_addr = '0;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            m_tvalid_reg    <= 1'b0;
            cnt_reg         <= '0;
            itr_reg         <= '0;
            vel_count_reg   <= '0;
            long_count_reg  <= '0;
            trans_count_reg <= '0;
            const_vel_reg   <= CONST_VEL_RESET;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wen)
            begin
                unique case (cfg_addr)
                    REG_VEL_COUNT:   vel_count_reg   <= cfg_wdata[COUNT_W-1:0];
                    REG_LONG_COUNT:  long_count_reg  <= cfg_wdata[COUNT_W-1:0];
                    REG_TRANS_COUNT: trans_count_reg <= cfg_wdata[COUNT_W-1:0];
                    REG_CONST_VEL:   const_vel_reg   <= cfg_wdata;
                endcase
            end

            if ((state_reg == ST_OUT) && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:    cnt_reg <= '0;
                ST_SQ:      cnt_reg <= cnt_reg + 2'd1;
                ST_SQ_END:
                begin
                    cnt_reg <= '0;
                    itr_reg <= 7'd32;
                end
                ST_LK_DSET: itr_reg <= 7'd32;
                ST_LK_RET:  itr_reg <= 7'd64;
                ST_VC_CHK:  itr_reg <= 7'd32;
                ST_CV_DIV:  itr_reg <= (itr_reg == 7'd1) ? 7'd32 : itr_reg - 7'd1;
                ST_SQRT, ST_LK_DIV, ST_VC_DIV:
                            itr_reg <= itr_reg - 7'd1;
                ST_VC_NEXT: cnt_reg <= cnt_reg + 2'd1;
                default:    cnt_reg <= cnt_reg;
            endcase
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_reg         <= s_tuser;
                    mag_x_reg      <= in_ex[31] ? 32'd0 - in_ex : in_ex;
                    mag_y_reg      <= in_ey[31] ? 32'd0 - in_ey : in_ey;
                    mag_z_reg      <= in_ez[31] ? 32'd0 - in_ez : in_ez;
                    neg_reg        <= {in_ez[31], in_ey[31], in_ex[31]};
                    key_reg        <= in_key;
                    raw_reg        <= in_val;
                    idx_reg        <= in_idx_w;
                    res_status_reg <= in_is_query && in_b_nz;
                    res_vx_reg     <= '0;
                    res_vy_reg     <= '0;
                    res_vz_reg     <= '0;
                    res_dl_reg     <= '0;
                    res_dt_reg     <= '0;
                    // diffusion loads first look up velocity at the key
                    lk_ctx_reg     <= LC_VLOAD;
                    lk_tab_reg     <= TB_VEL;
                    lk_n_reg       <= NW'(nv);
                    lk_e_reg       <= in_key;
                end
            end
            ST_SQ:
            begin
                prod_reg <= mul_p;
                acc_reg  <= (cnt_reg == 2'd0) ? 64'd0 : acc_reg + prod_reg;
            end
            ST_SQ_END:
            begin
                sx_reg    <= acc_reg + prod_reg;
                srem_reg  <= '0;
                sroot_reg <= '0;
            end
            ST_SQRT:
            begin
                sx_reg    <= {sx_reg[61:0], 2'b00};
                srem_reg  <= srem_n;
                sroot_reg <= sroot_n;
            end
            ST_SQ_RET:
            begin
                lk_res_reg <= sroot_reg;
                e_reg      <= sroot_reg;
                lk_e_reg   <= sroot_reg;
                priority if (op_reg == OP_VEL_QUERY)
                begin
                    lk_ctx_reg <= LC_VQUERY;
                    lk_tab_reg <= TB_VEL;
                    lk_n_reg   <= NW'(nv);
                end
                else if (nl != '0)
                begin
                    lk_ctx_reg <= LC_LONG;
                    lk_tab_reg <= TB_LONG;
                    lk_n_reg   <= NW'(nl);
                end
                else
                begin
                    lk_ctx_reg <= LC_TRANS;
                    lk_tab_reg <= TB_TRANS;
                    lk_n_reg   <= NW'(nt);
                end
            end
            ST_LK_A0:
            begin
                lk_res_reg <= const_vel_reg;    // empty velocity table
            end
            ST_LK_AN:
            begin
                lk_k0_reg <= rd_key;
                lk_y0_reg <= rd_val;
            end
            ST_LK_CHK:
            begin
                lk_yn_reg  <= rd_val;
                lk_res_reg <= (lk_e_reg < lk_k0_reg) ? lk_y0_reg : rd_val;
                lk_i_reg   <= NW'(1);
            end
            ST_LK_SCAN:
            begin
                if (rd_key > lk_e_reg)
                begin
                    lk_k1_reg  <= rd_key;
                    lk_y1_reg  <= rd_val;
                    lk_res_reg <= lk_y0_reg;
                end
                else
                begin
                    lk_k0_reg  <= rd_key;
                    lk_y0_reg  <= rd_val;
                    lk_res_reg <= lk_yn_reg;
                    lk_i_reg   <= lk_ip1;
                end
            end
            ST_LK_MUL:
            begin
                prod_reg  <= mul_p;
                lk_up_reg <= lk_y1_reg >= lk_y0_reg;
            end
            ST_LK_DSET:
            begin
                // E - k0 < k1 - k0, so the quotient fits 32 bits
                div_rem_reg <= prod_reg[63:32];
                div_q_reg   <= {prod_reg[31:0], 32'd0};
                div_d_reg   <= lk_k1_reg - lk_k0_reg;
            end
            ST_LK_DIV:
            begin
                div_rem_reg <= div_rem_n;
                div_q_reg   <= div_q_n;
            end
            ST_LK_FIN:
            begin
                lk_res_reg <= lk_up_reg ? lk_y0_reg + div_q_reg[31:0]
                                        : lk_y0_reg - div_q_reg[31:0];
            end
            ST_LK_RET:
            begin
                unique case (lk_ctx_reg)
                    LC_VLOAD:
                    begin
                        if (cv_sat)
                            lk_res_reg <= 32'hFFFF_FFFF;
                        // 2*D*2^40 / v as draw*2^41, 64 quotient bits
                        div_rem_reg <= {15'd0, raw_reg[39:23]};
                        div_q_reg   <= {raw_reg[22:0], 41'd0};
                        div_d_reg   <= lk_res_reg;
                    end
                    LC_VQUERY:
                    begin
                        vel_v_reg <= lk_res_reg;
                    end
                    LC_LONG:
                    begin
                        res_dl_reg <= lk_res_reg;
                        if (nt == '0)
                            res_dt_reg <= lk_res_reg;
                        lk_ctx_reg <= LC_TRANS;
                        lk_tab_reg <= TB_TRANS;
                        lk_n_reg   <= NW'(nt);
                    end
                    LC_TRANS:
                    begin
                        res_dt_reg <= lk_res_reg;
                        if (nl == '0)
                            res_dl_reg <= lk_res_reg;
                    end
                endcase
            end
            ST_CV_DIV:
            begin
                div_rem_reg <= div_rem_n;
                div_q_reg   <= div_q_n;
                sx_reg      <= div_q_n;
                srem_reg    <= '0;
                sroot_reg   <= '0;
            end
            ST_VC_MUL:
            begin
                prod_reg <= mul_p;
            end
            ST_VC_CHK:
            begin
                cm_reg      <= 32'hFFFF_FFFF;   // saturates when quotient >= 2^32
                div_rem_reg <= prod_reg[63:32];
                div_q_reg   <= {prod_reg[31:0], 32'd0};
                div_d_reg   <= e_reg;
            end
            ST_VC_DIV:
            begin
                div_rem_reg <= div_rem_n;
                div_q_reg   <= div_q_n;
                cm_reg      <= div_q_n[31:0];
            end
            ST_VC_NEXT:
            begin
                unique case (cnt_reg)
                    2'd0:    res_vx_reg <= vc_val;
                    2'd1:    res_vy_reg <= vc_val;
                    default: res_vz_reg <= vc_val;
                endcase
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    m_data_reg <= {5'd0, res_dt_reg, res_dl_reg,
                                   res_vz_reg, res_vy_reg, res_vx_reg};
                    m_user_reg <= res_status_reg;
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // ---------------- assertions ----------------
    `DTI_ASSERT_IMP(a_one_table_write, clk, rst_n, 1'b1, $onehot0({we_vel, we_long, we_trans}), "more than one table written")
    `DTI_ASSERT_NXT(a_one_item, clk, rst_n, s_tvalid && s_tready, !s_tready, "second item taken while busy")
    `DTI_ASSERT_IMP(a_div_bound, clk, rst_n, (state_reg == ST_LK_DIV) || (state_reg == ST_CV_DIV) || (state_reg == ST_VC_DIV), div_rem_reg < div_d_reg, "divider remainder out of range")
    `DTI_ASSERT_IMP(a_iter_live, clk, rst_n, (state_reg == ST_SQRT) || (state_reg == ST_LK_DIV) || (state_reg == ST_CV_DIV) || (state_reg == ST_VC_DIV), itr_reg != 7'd0, "step counter ran out")

endmodule

[design/dti_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read address per cycle, registered read data.
// ----------------------------------------------------------------------------
module dti_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[dv/drift_table_interpolator_test.sv]
// ----------------------------------------------------------------------------
// Drift table interpolator testbench
// Drives load and query transfers into the table interpolator, predicts every
// result with an independent model of the tables and arithmetic, and checks
// each result transfer field by field, under random idling and back-pressure.
// ----------------------------------------------------------------------------
module drift_table_interpolator_test
    import dti_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT = 4000000;
    localparam logic [63:0] MASK32      = 64'hFFFF_FFFF;
    localparam logic [63:0] MASK33      = 64'h1_FFFF_FFFF;

    // one input item, field for field
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [31:0]      ex, ey, ez, bx, by, bz;
        logic [IDX_W-1:0] index;
        logic [31:0]      key;
        logic [39:0]      value;
    } drift_item_t;

    // one result item
    typedef struct packed {
        logic        status;
        logic [32:0] vel_x, vel_y, vel_z;
        logic [31:0] diff_long, diff_trans;
    } drift_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [OP_W-1:0]       s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    drift_table_interpolator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: register copies and the three tables
    // ------------------------------------------------------------------
    logic [6:0]  vel_cnt, long_cnt, trans_cnt;
    logic [31:0] const_vel;
    logic [31:0] tbl_key [3][DTI_TABLE_DEPTH];
    logic [31:0] tbl_val [3][DTI_TABLE_DEPTH];

    drift_result_t expected_q[$];
    int            fail_count = 0;
    int            cycle_count = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            hold_req = 0;        // bumped by a test to start a hold-off
    int            hold_seen = 0;
    int            hold_cycles = 0;

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic int clip_count(input logic [6:0] c);
        return (c > DTI_TABLE_DEPTH) ? DTI_TABLE_DEPTH : int'(c);
    endfunction

    // clamped piecewise-linear interpolation, step truncated toward the lower row
    function automatic logic [31:0] table_interp(input int t, input int n,
                                                 input logic [31:0] e);
        int          i;
        logic [63:0] k0, k1, y0, y1, dt, dx;
        if (e < tbl_key[t][0])
            return tbl_val[t][0];
        if (e > tbl_key[t][n-1])
            return tbl_val[t][n-1];
        for (i = 1; i < n; i++)
            if (tbl_key[t][i] > e)
                break;
        if (i >= n)
            return tbl_val[t][n-1];
        k0 = tbl_key[t][i-1];
        k1 = tbl_key[t][i];
        y0 = tbl_val[t][i-1];
        y1 = tbl_val[t][i];
        if (k1 <= k0)
            return y0[31:0];
        dt = {32'd0, e} - k0;
        dx = k1 - k0;
        if (y1 >= y0)
            return 32'(y0 + (y1 - y0) * dt / dx);
        return 32'(y0 - (y0 - y1) * dt / dx);
    endfunction

    function automatic logic [31:0] drift_velocity_at(input logic [31:0] e);
        int n;
        n = clip_count(vel_cnt);
        if (n == 0)
            return const_vel;
        return table_interp(TB_VEL, n, e);
    endfunction

    // sqrt(2*D/v) in Q12.20: integer quotient, then 41 fraction bits, then root
    function automatic logic [31:0] diffusion_coef(input logic [39:0] d_raw,
                                                   input logic [31:0] v_raw);
        logic [63:0] q1, rem, ql, q;
        if (v_raw == 0)
            return '1;
        q1  = {24'd0, d_raw} / v_raw;
        rem = {24'd0, d_raw} % v_raw;
        if (q1 >= (64'd1 << 23))
            return '1;
        ql = '0;
        for (int b = 0; b < 41; b++)
        begin
            rem = rem << 1;
            ql  = ql << 1;
            if (rem >= v_raw)
            begin
                rem   = rem - v_raw;
                ql[0] = 1'b1;
            end
        end
        q = int_sqrt((q1 << 41) + ql);
        return (q > MASK32) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    // -e*V/E per axis, saturated, two's complement in 33 bits
    function automatic logic [32:0] drift_component(input logic [31:0] raw,
                                                    input logic [63:0] v,
                                                    input logic [63:0] e);
        logic [63:0] mag, m;
        mag = raw[31] ? ((~{32'd0, raw} + 1) & MASK32) : {32'd0, raw};
        m   = mag * v / e;
        if (m > MASK32)
            m = MASK32;
        if (!raw[31] && m != 0)
            return 33'((64'd0 - m) & MASK33);
        return m[32:0];
    endfunction

    function automatic logic [63:0] abs_sq(input logic [31:0] raw);
        logic [63:0] mag;
        mag = raw[31] ? ((~{32'd0, raw} + 1) & MASK32) : {32'd0, raw};
        return mag * mag;
    endfunction

    // updates the tables for loads and returns the result of the item
    function automatic drift_result_t predict_result(input drift_item_t it);
        drift_result_t res;
        logic [63:0]   e;
        logic [31:0]   v;
        int            nl, nt;
        res = '0;
        if (it.op == OP_LOAD_VEL)
        begin
            tbl_key[TB_VEL][it.index] = it.key;
            tbl_val[TB_VEL][it.index] = (it.value > MASK32) ? 32'hFFFF_FFFF : it.value[31:0];
            return res;
        end
        if (it.op == OP_LOAD_LONG || it.op == OP_LOAD_TRANS)
        begin
            v = drift_velocity_at(it.key);
            if (it.op == OP_LOAD_LONG)
            begin
                tbl_key[TB_LONG][it.index] = it.key;
                tbl_val[TB_LONG][it.index] = diffusion_coef(it.value, v);
            end
            else
            begin
                tbl_key[TB_TRANS][it.index] = it.key;
                tbl_val[TB_TRANS][it.index] = diffusion_coef(it.value, v);
            end
            return res;
        end
        if (it.op != OP_VEL_QUERY && it.op != OP_DIFF_QUERY)
            return res;
        if (it.bx != 0 || it.by != 0 || it.bz != 0)
        begin
            res.status = 1'b1;
            return res;
        end
        // three squares of at most 2^62 each fit in 64 bits
        e = int_sqrt(abs_sq(it.ex) + abs_sq(it.ey) + abs_sq(it.ez));
        if (it.op == OP_VEL_QUERY)
        begin
            if (e == 0)
                return res;
            v = drift_velocity_at(e[31:0]);
            res.vel_x = drift_component(it.ex, 64'(v), e);
            res.vel_y = drift_component(it.ey, 64'(v), e);
            res.vel_z = drift_component(it.ez, 64'(v), e);
            return res;
        end
        nl = clip_count(long_cnt);
        nt = clip_count(trans_cnt);
        if (nl == 0 && nt == 0)
            return res;
        if (nl == 0)
        begin
            res.diff_long  = table_interp(TB_TRANS, nt, e[31:0]);
            res.diff_trans = res.diff_long;
        end
        else if (nt == 0)
        begin
            res.diff_long  = table_interp(TB_LONG, nl, e[31:0]);
            res.diff_trans = res.diff_long;
        end
        else
        begin
            res.diff_long  = table_interp(TB_LONG, nl, e[31:0]);
            res.diff_trans = table_interp(TB_TRANS, nt, e[31:0]);
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Run watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side: random tready, plus a counted hold-off for pressure
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen   <= hold_req;
            hold_cycles <= 3000;
            m_tready    <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            m_tready    <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // every result transfer is checked against the oldest prediction
    always @(posedge clk)
    begin
        drift_result_t want, got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status     = m_tuser;
            got.vel_x      = m_tdata[32:0];
            got.vel_y      = m_tdata[65:33];
            got.vel_z      = m_tdata[98:66];
            got.diff_long  = m_tdata[130:99];
            got.diff_trans = m_tdata[162:131];
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result transfer %h", $time, got);
                fail_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.status != want.status)
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, got.status);
                if (got.vel_x != want.vel_x)
                    $display("%0t: vel_x expected %h actual %h", $time, want.vel_x, got.vel_x);
                if (got.vel_y != want.vel_y)
                    $display("%0t: vel_y expected %h actual %h", $time, want.vel_y, got.vel_y);
                if (got.vel_z != want.vel_z)
                    $display("%0t: vel_z expected %h actual %h", $time, want.vel_z, got.vel_z);
                if (got.diff_long != want.diff_long)
                    $display("%0t: diff_long expected %h actual %h", $time,
                             want.diff_long, got.diff_long);
                if (got.diff_trans != want.diff_trans)
                    $display("%0t: diff_trans expected %h actual %h", $time,
                             want.diff_trans, got.diff_trans);
                if (got != want)
                    fail_count++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // offers one item, leaves tvalid high after the transfer so that
    // back-to-back items keep it asserted
    task automatic send_item(input drift_item_t it);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {2'd0, it.value, it.key, it.index, it.bz, it.by, it.bx,
                     it.ez, it.ey, it.ex};
        do
            @(posedge clk);
        while (!s_tready);
        expected_q.push_back(predict_result(it));
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // register writes on consecutive cycles, only while the block is idle
    task automatic program_regs(input logic [31:0] vc, input logic [31:0] lc,
                                input logic [31:0] tc, input logic [31:0] cv);
        logic [31:0] vals [4];
        vals = '{vc, lc, tc, cv};
        for (int r = 0; r < 4; r++)
        begin
            @(negedge clk);
            cfg_wen   <= 1'b1;
            cfg_addr  <= CFG_IDX_W'(r);
            cfg_wdata <= vals[r];
        end
        @(negedge clk);
        cfg_wen   <= 1'b0;
        vel_cnt   = vc[6:0];
        long_cnt  = lc[6:0];
        trans_cnt = tc[6:0];
        const_vel = cv;
    endtask

    function automatic drift_item_t blank_item(input logic [OP_W-1:0] op);
        drift_item_t it;
        it    = '0;
        it.op = op;
        return it;
    endfunction

    // field component: mostly inside the table key span, sometimes anything
    function automatic logic [31:0] rand_field();
        logic [31:0] m;
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return '0;
            default:
            begin
                m = $urandom_range(0, 1 << 20);
                return $urandom_range(1) ? -m : m;
            end
        endcase
    endfunction

    function automatic logic [31:0] rand_count();
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'd64;
            3:       return $urandom_range(65, 127);
            4:       return 32'({$urandom, 7'd0} | $urandom_range(0, 64)); // upper bits ignored
            default: return $urandom_range(2, 64);
        endcase
    endfunction

    function automatic drift_item_t rand_item();
        drift_item_t it;
        int          pick;
        it       = '0;
        pick     = $urandom_range(99);
        it.op    = (pick < 40) ? OP_VEL_QUERY :
                   (pick < 72) ? OP_DIFF_QUERY :
                   (pick < 80) ? OP_LOAD_VEL :
                   (pick < 88) ? OP_LOAD_LONG :
                   (pick < 96) ? OP_LOAD_TRANS : OP_W'($urandom_range(5, 7));
        it.ex    = rand_field();
        it.ey    = rand_field();
        it.ez    = rand_field();
        if ($urandom_range(19) == 0)
            case ($urandom_range(2))
                0:       it.bx = $urandom;
                1:       it.by = $urandom;
                default: it.bz = $urandom;
            endcase
        it.index = IDX_W'($urandom_range(0, 63));
        it.key   = $urandom_range(1) ? $urandom_range(0, 1 << 20) : $urandom;
        it.value = 40'({$urandom, $urandom} >> $urandom_range(24, 48));
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // empty tables: constant velocity, field extremes, magnetic field,
    // unused ops, saturating loads and zero velocity on a diffusion load
    task automatic test_directed();
        drift_item_t it;
        send_item(blank_item(OP_DIFF_QUERY));               // no diffusion tables
        send_item(blank_item(OP_VEL_QUERY));                // zero field
        it = blank_item(OP_VEL_QUERY);
        it.ex = 32'h7FFF_FFFF;
        send_item(it);
        it.ex = 32'h8000_0000;
        it.ey = 32'h8000_0000;
        it.ez = 32'h7FFF_FFFF;
        send_item(it);
        it = blank_item(OP_VEL_QUERY);
        it.ez = 32'hFFFF_FF00;
        send_item(it);
        it.bx = 32'd1;
        send_item(it);
        it.bx = '0;
        it.by = 32'h8000_0000;
        it.op = OP_DIFF_QUERY;
        send_item(it);
        it.by = '0;
        it.bz = 32'hFFFF_FFFF;
        send_item(it);
        for (int op = 5; op < 8; op++)
        begin
            it = blank_item(OP_W'(op));
            it.ex = 32'h0000_1000;
            send_item(it);
        end
        it = blank_item(OP_LOAD_VEL);
        it.index = 6'd63;
        it.key   = 32'hFFFF_FFFF;
        it.value = 40'hFF_FFFF_FFFF;
        send_item(it);
        it.op = OP_LOAD_LONG;                               // constant velocity
        send_item(it);
        it.op    = OP_LOAD_TRANS;
        it.value = '0;
        send_item(it);
        drain_results();
        program_regs(0, 0, 0, 32'd0);
        it = blank_item(OP_LOAD_LONG);                      // zero velocity
        it.value = 40'd12345;
        send_item(it);
        it = blank_item(OP_VEL_QUERY);
        it.ex = 32'h0001_0000;
        send_item(it);
        drain_results();
        program_regs(0, 0, 0, 32'hFFFF_FFFF);
        send_item(it);
        it.ex = 32'hFFFF_0000;
        send_item(it);
        it = blank_item(OP_LOAD_LONG);
        it.index = 6'd1;
        it.value = 40'hFF_FFFF_FFFF;
        send_item(it);
        drain_results();
    endtask

    // every row of every table written with non-decreasing keys, so that any
    // count from here on reads only loaded rows
    task automatic test_table_fill();
        drift_item_t it;
        logic [31:0] k;
        program_regs(0, 0, 0, CONST_VEL_RESET);
        for (int t = 0; t < 3; t++)
        begin
            k = $urandom_range(0, 256);
            for (int i = 0; i < DTI_TABLE_DEPTH; i++)
            begin
                it       = blank_item((t == 0) ? OP_LOAD_VEL :
                                      (t == 1) ? OP_LOAD_LONG : OP_LOAD_TRANS);
                it.index = IDX_W'(i);
                it.key   = k;
                it.value = (t == 0) ? 40'($urandom) : 40'({$urandom, $urandom} >> 24);
                send_item(it);
                k = k + (($urandom_range(9) == 0) ? 0 : $urandom_range(1, 1 << 14));
            end
            if (t == 0)
            begin
                drain_results();
                program_regs(64, 0, 0, CONST_VEL_RESET);
            end
        end
        drain_results();
    endtask

    task automatic test_random(input int phases, input int items_per_phase);
        for (int p = 0; p < phases; p++)
        begin
            program_regs(rand_count(), rand_count(), rand_count(),
                         ($urandom_range(3) == 0) ? CONST_VEL_RESET : $urandom);
            repeat (items_per_phase)
                send_item(rand_item());
            drain_results();
        end
    endtask

    // receiver stops for a long stretch while items keep coming
    task automatic test_backpressure();
        program_regs(64, 64, 64, CONST_VEL_RESET);
        send_idle_pct = 0;
        hold_req      = hold_req + 1;
        repeat (30)
            send_item(rand_item());
        drain_results();
    endtask

    initial
    begin
        vel_cnt   = '0;
        long_cnt  = '0;
        trans_cnt = '0;
        const_vel = CONST_VEL_RESET;
        for (int t = 0; t < 3; t++)
            for (int i = 0; i < DTI_TABLE_DEPTH; i++)
            begin
                tbl_key[t][i] = '0;
                tbl_val[t][i] = '0;
            end
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 16;
        recv_idle_pct = 74;
        test_directed();
        test_table_fill();
        test_random(3, 185);

        send_idle_pct = 74;
        recv_idle_pct = 16;
        test_random(3, 185);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(3, 185);
        test_backpressure();

        repeat (300) @(posedge clk);
        if (fail_count == 0 && expected_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
